// File: rtl/pserm_pkg.sv
// Shared types and codes for the per-source event ring buffer.
package pserm_pkg;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NONE     = 3'd1;
  localparam logic [2:0] ST_INVALID  = 3'd2;
  localparam logic [2:0] ST_NOSPACE  = 3'd3;
  localparam logic [2:0] ST_STALE    = 3'd4;
  localparam logic [2:0] ST_RANGE    = 3'd5;
  localparam logic [2:0] ST_OVERFLOW = 3'd6;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  source_index;
    logic [15:0] in_kind;
    logic [63:0] in_value;
    logic [63:0] in_address;
    logic [63:0] after_sequence;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] out_kind;
    logic [63:0] out_value;
    logic [63:0] out_address;
    logic [7:0]  out_source;
    logic [63:0] out_sequence;
    logic [63:0] lost_total;
  } result_t;

  typedef struct packed {
    logic [63:0] sequence_num;
    logic [15:0] kind;
    logic [63:0] value;
    logic [63:0] address;
  } slot_t;

  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_t;

endpackage

// File: rtl/pserm_slot_ram.sv
// Ring slot storage: one write port, one registered read port.
module pserm_slot_ram
  import pserm_pkg::*;
#(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  slot_t         wdata_i,
  input  logic [AW-1:0] raddr_i,
  output slot_t         rdata_o
);

  slot_t mem [DEPTH];
  slot_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/pserm_cmp.sv
// Shared 64-bit magnitude comparator.
module pserm_cmp
  import pserm_pkg::*;
(
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output cmp_t        res_o
);

  assign res_o.lt = (a_i < b_i);
  assign res_o.eq = (a_i == b_i);

endmodule

// File: rtl/per_source_event_rings_sequenced_merge.sv
// Per-source event rings with a global sequence: sequencer, ring state and slot memory.
// Push: a bad source or a full ring ends the push early, else a pending loss event may
// be written ahead of the item. Pop: mark, last-sequence and maximum checks (a rejected
// pop stops at its failing check), then a discard pass and a selection pass over the
// ring heads, then the result is registered and strobed. One item at a time; the next
// may be accepted in the strobe cycle, which cannot be stalled. Reset clears pointers,
// drop counters, sequence and mark; slot memory is not cleared.
module per_source_event_rings_sequenced_merge
  import pserm_pkg::*;
#(
  parameter int RING_SLOTS   = 256,
  parameter int SOURCE_COUNT = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  item_t       item_i,
  output logic        result_valid_o,
  output result_t     result_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  localparam int SW    = (SOURCE_COUNT > 1) ? $clog2(SOURCE_COUNT) : 1;
  localparam int SCW   = $clog2(SOURCE_COUNT + 1);
  localparam int PW    = $clog2(2 * RING_SLOTS);
  localparam int DEPTH = SOURCE_COUNT * RING_SLOTS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [PW-1:0] PTR_LAST = PW'(2 * RING_SLOTS - 1);
  localparam logic [PW-1:0] RING_PW  = PW'(RING_SLOTS);
  localparam logic [PW-1:0] ROOM_TWO = PW'(RING_SLOTS - 2);

  // Sequencer codes
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_PUSH     = 4'd1;
  localparam logic [3:0] S_PUSH_EV  = 4'd2;
  localparam logic [3:0] S_CHK_MARK = 4'd3;
  localparam logic [3:0] S_CHK_LAST = 4'd4;
  localparam logic [3:0] S_CHK_MAX  = 4'd5;
  localparam logic [3:0] S_DSC_RD   = 4'd6;
  localparam logic [3:0] S_DSC_CMP  = 4'd7;
  localparam logic [3:0] S_SEL_RD   = 4'd8;
  localparam logic [3:0] S_SEL_CMP  = 4'd9;
  localparam logic [3:0] S_FIN      = 4'd10;

  logic [3:0]    state_q, state_d;
  item_t         item_q, item_d;
  logic [SCW-1:0] scan_q, scan_d;
  logic [63:0]   expect_q, expect_d;
  logic [2:0]    status_q, status_d;
  slot_t         pop_q, pop_d;
  logic [7:0]    pop_src_q, pop_src_d;
  result_t       res_q, res_d;
  logic          strobe_q, strobe_d;
  logic [PW-1:0] wp_q [SOURCE_COUNT];
  logic [PW-1:0] wp_d [SOURCE_COUNT];
  logic [PW-1:0] rp_q [SOURCE_COUNT];
  logic [PW-1:0] rp_d [SOURCE_COUNT];
  logic [63:0]   dt_q [SOURCE_COUNT];
  logic [63:0]   dt_d [SOURCE_COUNT];
  logic [63:0]   dp_q [SOURCE_COUNT];
  logic [63:0]   dp_d [SOURCE_COUNT];
  logic [63:0]   last_q, last_d;
  logic [63:0]   mark_q, mark_d;
  logic [15:0]   kind_q;

  logic [SW-1:0] cur;
  logic [PW-1:0] cur_wp, cur_rp, used, rd_slot, wr_slot;
  logic [AW-1:0] raddr, waddr;
  logic          we;
  slot_t         wdata, rdata;
  logic [63:0]   cmp_a, cmp_b;
  cmp_t          cmp;
  logic          src_ok;

  pserm_slot_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  pserm_cmp u_cmp (
    .a_i   (cmp_a),
    .b_i   (cmp_b),
    .res_o (cmp)
  );

  assign src_ok = ({1'b0, item_q.source_index} < 9'(SOURCE_COUNT));

  // Pushes address the item's ring; the pop passes walk the scan counter.
  assign cur = (state_q == S_PUSH || state_q == S_PUSH_EV) ?
               item_q.source_index[SW-1:0] : scan_q[SW-1:0];
  assign cur_wp = wp_q[cur];
  assign cur_rp = rp_q[cur];
  assign used   = (cur_wp >= cur_rp) ? (cur_wp - cur_rp) : PW'(cur_wp + RING_PW + RING_PW - cur_rp);
  assign rd_slot = (cur_rp >= RING_PW) ? (cur_rp - RING_PW) : cur_rp;
  assign wr_slot = (cur_wp >= RING_PW) ? (cur_wp - RING_PW) : cur_wp;
  assign raddr = AW'(AW'(cur) * AW'(RING_SLOTS) + AW'(rd_slot));
  assign waddr = AW'(AW'(cur) * AW'(RING_SLOTS) + AW'(wr_slot));

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PTR_LAST) ? '0 : p + PW'(1);
  endfunction

  // Route the shared comparator by step
  always_comb begin
    cmp_a = '0;
    cmp_b = '0;
    case (state_q)
      S_PUSH, S_PUSH_EV: begin
        cmp_a = last_q;
        cmp_b = '1;
      end
      S_CHK_MARK: begin
        cmp_a = item_q.after_sequence;
        cmp_b = mark_q;
      end
      S_CHK_LAST: begin
        cmp_a = last_q;
        cmp_b = item_q.after_sequence;
      end
      S_CHK_MAX: begin
        cmp_a = item_q.after_sequence;
        cmp_b = '1;
      end
      S_DSC_CMP: begin
        cmp_a = rdata.sequence_num;
        cmp_b = item_q.after_sequence;
      end
      S_SEL_CMP: begin
        cmp_a = rdata.sequence_num;
        cmp_b = expect_q;
      end
      default: begin
        cmp_a = '0;
      end
    endcase
  end

  always_comb begin
    state_d   = state_q;
    item_d    = item_q;
    scan_d    = scan_q;
    expect_d  = expect_q;
    status_d  = status_q;
    pop_d     = pop_q;
    pop_src_d = pop_src_q;
    res_d     = res_q;
    strobe_d  = 1'b0;
    wp_d      = wp_q;
    rp_d      = rp_q;
    dt_d      = dt_q;
    dp_d      = dp_q;
    last_d    = last_q;
    mark_d    = mark_q;
    we        = 1'b0;
    wdata     = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          item_d    = item_i;
          pop_d     = '0;
          pop_src_d = '0;
          scan_d    = '0;
          state_d   = (item_i.cmd == CMD_POP) ? S_CHK_MARK : S_PUSH;
        end
      end
      S_PUSH: begin
        if (!src_ok) begin
          status_d = ST_INVALID;
          state_d  = S_FIN;
        end else if (used == RING_PW) begin
          // Ring full: drop and count
          dt_d[cur] = dt_q[cur] + 64'd1;
          dp_d[cur] = dp_q[cur] + 64'd1;
          status_d  = ST_NOSPACE;
          state_d   = S_FIN;
        end else if (dp_q[cur] != '0 && used <= ROOM_TWO) begin
          if (cmp.eq) begin
            status_d = ST_OVERFLOW;
            state_d  = S_FIN;
          end else begin
            // Insert the loss event ahead of the item
            we                 = 1'b1;
            wdata.sequence_num = last_q + 64'd1;
            wdata.kind         = kind_q;
            wdata.value        = dp_q[cur];
            wdata.address      = dt_q[cur];
            last_d             = last_q + 64'd1;
            wp_d[cur]          = ptr_inc(cur_wp);
            dp_d[cur]          = '0;
            state_d            = S_PUSH_EV;
          end
        end else begin
          state_d = S_PUSH_EV;
        end
      end
      S_PUSH_EV: begin
        if (cmp.eq) begin
          status_d = ST_OVERFLOW;
        end else begin
          we                 = 1'b1;
          wdata.sequence_num = last_q + 64'd1;
          wdata.kind         = item_q.in_kind;
          wdata.value        = item_q.in_value;
          wdata.address      = item_q.in_address;
          last_d             = last_q + 64'd1;
          wp_d[cur]          = ptr_inc(cur_wp);
          status_d           = ST_OK;
        end
        state_d = S_FIN;
      end
      S_CHK_MARK: begin
        if (cmp.lt) begin
          status_d = ST_STALE;
          state_d  = S_FIN;
        end else begin
          state_d = S_CHK_LAST;
        end
      end
      S_CHK_LAST: begin
        if (cmp.lt) begin
          status_d = ST_RANGE;
          state_d  = S_FIN;
        end else begin
          state_d = S_CHK_MAX;
        end
      end
      S_CHK_MAX: begin
        if (cmp.eq) begin
          status_d = ST_OVERFLOW;
          state_d  = S_FIN;
        end else begin
          expect_d = item_q.after_sequence + 64'd1;
          state_d  = S_DSC_RD;
        end
      end
      S_DSC_RD: begin
        if (scan_q == SCW'(SOURCE_COUNT)) begin
          mark_d  = item_q.after_sequence;
          scan_d  = '0;
          state_d = S_SEL_RD;
        end else if (used == '0) begin
          scan_d = scan_q + SCW'(1);
        end else begin
          state_d = S_DSC_CMP;
        end
      end
      S_DSC_CMP: begin
        // Drop the head if already consumed, else move to the next ring
        if (cmp.lt || cmp.eq) begin
          rp_d[cur] = ptr_inc(cur_rp);
        end else begin
          scan_d = scan_q + SCW'(1);
        end
        state_d = S_DSC_RD;
      end
      S_SEL_RD: begin
        if (scan_q == SCW'(SOURCE_COUNT)) begin
          status_d = ST_NONE;
          state_d  = S_FIN;
        end else if (used == '0) begin
          scan_d = scan_q + SCW'(1);
        end else begin
          state_d = S_SEL_CMP;
        end
      end
      S_SEL_CMP: begin
        if (cmp.eq) begin
          pop_d     = rdata;
          pop_src_d = 8'(scan_q);
          rp_d[cur] = ptr_inc(cur_rp);
          mark_d    = expect_q;
          status_d  = ST_OK;
          state_d   = S_FIN;
        end else begin
          scan_d  = scan_q + SCW'(1);
          state_d = S_SEL_RD;
        end
      end
      S_FIN: begin
        res_d.status       = status_q;
        res_d.out_kind     = pop_q.kind;
        res_d.out_value    = pop_q.value;
        res_d.out_address  = pop_q.address;
        res_d.out_source   = pop_src_q;
        res_d.out_sequence = pop_q.sequence_num;
        res_d.lost_total   = src_ok ? dt_q[item_q.source_index[SW-1:0]] : '0;
        strobe_d           = 1'b1;
        state_d            = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      strobe_q <= 1'b0;
      last_q   <= '0;
      mark_q   <= '0;
      kind_q   <= 16'd1;
      scan_q   <= '0;
      for (int i = 0; i < SOURCE_COUNT; i++) begin
        wp_q[i] <= '0;
        rp_q[i] <= '0;
        dt_q[i] <= '0;
        dp_q[i] <= '0;
      end
    end else begin
      state_q  <= state_d;
      strobe_q <= strobe_d;
      last_q   <= last_d;
      mark_q   <= mark_d;
      scan_q   <= scan_d;
      wp_q     <= wp_d;
      rp_q     <= rp_d;
      dt_q     <= dt_d;
      dp_q     <= dp_d;
      if (cfg_we_i) begin
        kind_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    expect_q  <= expect_d;
    status_q  <= status_d;
    pop_q     <= pop_d;
    pop_src_q <= pop_src_d;
    res_q     <= res_d;
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = strobe_q;
  assign result_o       = res_q;

  a_strobe_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result strobe while sequencer busy");

  a_start_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted item did not start the sequencer");

  a_empty_fields : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.status != ST_OK) |-> (result_o.out_sequence == '0))
    else $error("popped fields set on a result without an event");

  a_pop_mark : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEL_CMP && cmp.eq) |=> (mark_q == $past(expect_q)))
    else $error("consumer mark not advanced on returned event");

endmodule
